// File: rtl/bloom_filter_murmur64_int_keys_core_assert.svh
// assertion macros for the bloom filter core
`ifndef BLOOM_FILTER_MURMUR64_INT_KEYS_CORE_ASSERT_SVH
`define BLOOM_FILTER_MURMUR64_INT_KEYS_CORE_ASSERT_SVH

// a | -> b, checked outside reset
`define BF_ASSERT_IMP(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a | => b, checked outside reset
`define BF_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// File: rtl/bfm64_pkg.sv
// ---------------------------------------------------------------------------
// bfm64_pkg
// shared constants and types of the bloom filter core
// ---------------------------------------------------------------------------
package bfm64_pkg;
   localparam int MAX_BITS   = 65536;
   localparam int MAX_PROBES = 16;
   localparam int ADDR_W     = $clog2(MAX_BITS);
   localparam int CNT_W      = $clog2(MAX_BITS) + 1;
   localparam int PRB_W      = $clog2(MAX_PROBES) + 1;
   localparam int CFG_W      = 17;

   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam logic [63:0] HASH_SEED = 64'h0000_0000_9747b28c;
   localparam int          MIX_SHIFT = 47;

   localparam logic REG_BIT_COUNT  = 1'b0;
   localparam logic REG_HASH_COUNT = 1'b1;
   localparam logic OP_INSERT      = 1'b0;

   // hash unit result
   typedef struct packed {
      logic        valid;
      logic [31:0] lo;
      logic [31:0] hi;
   } hash_out_type;

   function automatic logic [CNT_W-1:0] limit_bits(input logic [CFG_W-1:0] v);
      logic [CFG_W+3:0] t;
      begin
         t = {4'd0, v};
         if (t < (CFG_W+4)'(64)) t = (CFG_W+4)'(64);
         if (t > (CFG_W+4)'(MAX_BITS)) t = (CFG_W+4)'(MAX_BITS);
         t = (t + (CFG_W+4)'(7)) & ~(CFG_W+4)'(7);
         if (t > (CFG_W+4)'(MAX_BITS)) t = (CFG_W+4)'(MAX_BITS);
         return t[CNT_W-1:0];
      end
   endfunction

   function automatic logic [PRB_W-1:0] limit_probes(input logic [4:0] v);
      logic [PRB_W+4:0] t;
      begin
         t = {{PRB_W{1'b0}}, v};
         if (t < (PRB_W+5)'(1)) t = (PRB_W+5)'(1);
         if (t > (PRB_W+5)'(MAX_PROBES)) t = (PRB_W+5)'(MAX_PROBES);
         return t[PRB_W-1:0];
      end
   endfunction
endpackage

// File: rtl/bloom_filter_murmur64_int_keys_core.sv
// ---------------------------------------------------------------------------
// bloom_filter_murmur64_int_keys_core
// bloom filter over 64-bit keys with murmur64a double hashing
// ---------------------------------------------------------------------------
// A start beat is taken when start is high and busy is low. After reset the
// core clears its 65536-bit store one bit a cycle, with busy high. Each key
// then goes through the iterative hash unit (32x32 partial products), then
// per probe waits on the bit-serial remainder unit (launch, 32 steps, done),
// does one memory read and one check/write; a find stops at the first clear
// bit. From the accepting edge busy stays high until the last probe walked is
// checked, and a find's rsp_valid beat comes in the first cycle with busy
// low; an insert gives none. The receiver cannot stall: rsp_valid lasts one
// cycle. Config writes only while idle.
`include "bloom_filter_murmur64_int_keys_core_assert.svh"
module bloom_filter_murmur64_int_keys_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic signed [63:0]          req_key,
   output logic                        rsp_valid,
   output logic                        rsp_maybe_present,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [bfm64_pkg::CFG_W-1:0] csr_wdata
);
   import bfm64_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_CHECK = 3'd5;

   logic [2:0]        st_ff, st_in;
   logic [CNT_W-1:0]  nbits_ff;
   logic [PRB_W-1:0]  nprb_ff;
   logic              op_ff, op_in;
   logic [31:0]       lo_ff, lo_in, hi_ff, hi_in, mix_ff, mix_in;
   logic [PRB_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rv_ff, rv_in, rp_ff, rp_in;
   logic              hstart, mstart, mdone;
   logic [ADDR_W-1:0] mrem;
   hash_out_type      hout;

   // bit store and its write and read ports
   logic              mem [MAX_BITS];
   logic              we;
   logic [ADDR_W-1:0] waddr, raddr_ff;
   logic              wbit, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wbit;
      rdata_ff <= mem[mrem];
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nbits_ff <= limit_bits(CFG_W'(MAX_BITS));
         nprb_ff  <= limit_probes(5'd7);
      end else if (csr_we) begin
         if (csr_index == REG_BIT_COUNT) nbits_ff <= limit_bits(csr_wdata);
         else                            nprb_ff  <= limit_probes(csr_wdata[4:0]);
      end
   end

   bfm64_hash u_hash (
      .clock (clock), .reset (reset), .start (hstart), .key (req_key), .hout (hout)
   );
   bfm64_mod u_mod (
      .clock (clock), .reset (reset), .start (mstart), .dividend (mix_ff),
      .divisor (nbits_ff), .done (mdone), .rem (mrem)
   );

   always_comb begin
      st_in  = st_ff;
      op_in  = op_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      mix_in = mix_ff;
      idx_in = idx_ff;
      clr_in = clr_ff;
      rv_in  = 1'b0;
      rp_in  = rp_ff;
      hstart = 1'b0;
      we     = 1'b0;
      waddr  = mrem;
      wbit   = 1'b1;
      unique case (st_ff)
         ST_CLEAR: begin
            // sweep zeros through the store
            we     = 1'b1;
            waddr  = clr_ff;
            wbit   = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MAX_BITS - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               hstart = 1'b1;
               op_in  = req_opcode;
               st_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hout.valid) begin
               lo_in  = hout.lo;
               hi_in  = hout.hi;
               mix_in = hout.lo;
               idx_in = '0;
               st_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            // first cycle here kicks the remainder unit via mix_ff
            if (mdone) st_in = ST_READ;
         end
         ST_READ: begin
            // read data for mrem registers this cycle
            st_in = ST_CHECK;
         end
         default: begin
            if (op_ff == OP_INSERT) we = 1'b1;
            if (op_ff != OP_INSERT && !rdata_ff) begin
               rv_in = 1'b1;
               rp_in = 1'b0;
               st_in = ST_IDLE;
            end else if (idx_ff + 1'b1 >= nprb_ff) begin
               rv_in = (op_ff != OP_INSERT);
               rp_in = 1'b1;
               st_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               mix_in = mix_ff + hi_ff;
               st_in  = ST_MOD;
            end
         end
      endcase
   end

   // launch the remainder in the first cycle that mix_ff holds its new value
   logic go_ff;
   always_ff @(posedge clock) begin
      if (reset) go_ff <= 1'b0;
      else       go_ff <= (st_ff != ST_MOD) && (st_in == ST_MOD);
   end
   assign mstart = go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         rv_ff  <= rv_in;
      end
      op_ff    <= op_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mix_ff   <= mix_in;
      idx_ff   <= idx_in;
      rp_ff    <= rp_in;
      raddr_ff <= mrem;
   end

   assign busy              = (st_ff != ST_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_maybe_present = rp_ff;

   `BF_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rv_ff, !rv_ff, "rsp beat longer than a cycle")
   `BF_ASSERT_IMP(a_no_start_clear, clock, reset, st_ff == ST_CLEAR, busy, "idle during clear")
   `BF_ASSERT_IMP(a_wr_addr, clock, reset, we && st_ff == ST_CHECK, raddr_ff == mrem,
      "write address moved")
endmodule

// File: rtl/bfm64_hash.sv
// ---------------------------------------------------------------------------
// bfm64_hash
// murmur64a over one 8-byte block, one 64x64 product split in 32x32 parts
// ---------------------------------------------------------------------------
module bfm64_hash (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            key,
   output bfm64_pkg::hash_out_type hout
);
   import bfm64_pkg::*;

   // steps: 0 k*=m, 1 k^=k>>r, 2 k*=m, 3 h^=k, h*=m, 4 h^=h>>r, 5 h*=m, 6 h^=h>>r
   logic [2:0]  step_ff, step_in;
   logic [1:0]  part_ff, part_in;
   logic        run_ff, run_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] acc_ff, acc_in;
   logic        done_ff, done_in;
   logic [31:0] a_op, b_op;
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   // partial product selection: part 0 lo*lo, 1 lo*hi, 2 hi*lo
   always_comb begin
      a_op = x_ff[31:0];
      b_op = MIX_MUL[31:0];
      case (part_ff)
         2'd1: b_op = MIX_MUL[63:32];
         2'd2: a_op = x_ff[63:32];
         default: ;
      endcase
      prod_in = a_op * b_op;
   end

   always_ff @(posedge clock) prod_ff <= prod_in;

   always_comb begin
      step_in = step_ff;
      part_in = part_ff;
      run_in  = run_ff;
      x_in    = x_ff;
      h_in    = h_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start && !run_ff) begin
         run_in  = 1'b1;
         step_in = 3'd0;
         part_in = 2'd0;
         x_in    = key;
         h_in    = HASH_SEED ^ (MIX_MUL << 3);
         acc_in  = '0;
      end else if (run_ff) begin
         if (step_ff == 3'd1 || step_ff == 3'd4 || step_ff == 3'd6) begin
            x_in = x_ff ^ (x_ff >> MIX_SHIFT);
            if (step_ff == 3'd6) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
            step_in = step_ff + 3'd1;
         end else if (step_ff == 3'd3 && part_ff == 2'd0 && acc_ff == '0 && h_ff != '0)
         begin
            // fold k into h, then multiply h
            x_in   = h_ff ^ x_ff;
            h_in   = '0;
            acc_in = 64'd1;
         end else begin
            // mult steps: part 0..2 issue, part 3 collect last
            unique case (part_ff)
               2'd0: begin
                  part_in = 2'd1;
                  acc_in  = '0;
               end
               2'd1: begin
                  acc_in  = prod_ff;
                  part_in = 2'd2;
               end
               2'd2: begin
                  acc_in  = acc_ff + {prod_ff[31:0], 32'd0};
                  part_in = 2'd3;
               end
               default: begin
                  x_in    = acc_ff + {prod_ff[31:0], 32'd0};
                  part_in = 2'd0;
                  acc_in  = '0;
                  step_in = step_ff + 3'd1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         part_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
         part_ff <= part_in;
      end
      x_ff   <= x_in;
      h_ff   <= h_in;
      acc_ff <= acc_in;
   end

   assign hout.valid = done_ff;
   assign hout.lo    = x_ff[31:0];
   assign hout.hi    = x_ff[63:32];
endmodule

// File: rtl/bfm64_mod.sv
// ---------------------------------------------------------------------------
// bfm64_mod
// restoring 32-bit remainder, one bit per cycle
// ---------------------------------------------------------------------------
module bfm64_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   dividend,
   input  logic [bfm64_pkg::CNT_W-1:0]   divisor,
   output logic                          done,
   output logic [bfm64_pkg::ADDR_W-1:0]  rem
);
   import bfm64_pkg::*;

   logic [31:0]      num_ff, num_in;
   logic [CNT_W:0]   r_ff, r_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {r_ff[CNT_W-1:0], num_ff[31]};
      if (start) begin
         num_in = dividend;
         r_in   = '0;
         cnt_in = 6'd32;
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) r_in = trial - {1'b0, divisor};
         else r_in = trial;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      r_ff   <= r_in;
   end

   assign done = done_ff;
   assign rem  = r_ff[ADDR_W-1:0];
endmodule

// File: tb/bloom_filter_checker.sv
// ---------------------------------------------------------------------------
// bloom_filter_checker
// watches the key, result and config channels, predicts membership, compares results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module bloom_filter_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_opcode,
   input  logic [63:0]                 req_key,
   input  logic                        rsp_valid,
   input  logic                        rsp_maybe_present,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [bfm64_pkg::CFG_W-1:0] csr_wdata,
   output int                          fail_count,
   output int                          pending
);
   import bfm64_pkg::*;

   logic        filter_bits [0:MAX_BITS-1];
   logic [16:0] bits_in_use;
   logic [4:0]  probes_per_key;
   logic        presence_q [$];

   function automatic logic [16:0] clamp_bits(input logic [CFG_W-1:0] v);
      logic [20:0] t;
      begin
         t = {4'd0, v};
         if (t < 21'd64) t = 21'd64;
         if (t > 21'(MAX_BITS)) t = 21'(MAX_BITS);
         t = (t + 21'd7) & ~21'd7;
         if (t > 21'(MAX_BITS)) t = 21'(MAX_BITS);
         return t[16:0];
      end
   endfunction

   function automatic logic [4:0] clamp_probes(input logic [4:0] v);
      begin
         if (v == 0) return 5'd1;
         if (v > MAX_PROBES) return 5'(MAX_PROBES);
         return v;
      end
   endfunction

   function automatic logic [63:0] murmur_key(input logic [63:0] k);
      logic [63:0] h;
      begin
         h = HASH_SEED ^ (64'd8 * MIX_MUL);
         k = k * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         h = (h ^ k) * MIX_MUL;
         h = h ^ (h >> MIX_SHIFT);
         h = h * MIX_MUL;
         h = h ^ (h >> MIX_SHIFT);
         return h;
      end
   endfunction

   // inserts set the probed bits, finds return whether all are set
   function automatic logic apply_key(input logic op, input logic [63:0] k);
      logic [63:0] h;
      logic [31:0] mix;
      logic [31:0] pos;
      logic        all_set;
      begin
         h = murmur_key(k);
         all_set = 1'b1;
         for (int i = 0; i < probes_per_key; i++) begin
            mix = h[31:0] + 32'(i) * h[63:32];
            pos = mix % {15'd0, bits_in_use};
            if (op == OP_INSERT) begin
               filter_bits[pos] = 1'b1;
            end else if (!filter_bits[pos]) begin
               all_set = 1'b0;
               break;
            end
         end
         return all_set;
      end
   endfunction

   assign pending = presence_q.size();

   initial begin
      fail_count = 0;
      for (int i = 0; i < MAX_BITS; i++) filter_bits[i] = 1'b0;
      bits_in_use = clamp_bits(17'd65536);
      probes_per_key = clamp_probes(5'd7);
   end

   always @(posedge clock) begin
      logic want;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == REG_BIT_COUNT) bits_in_use = clamp_bits(csr_wdata);
            else probes_per_key = clamp_probes(csr_wdata[4:0]);
         end
         if (start && !busy) begin
            want = apply_key(req_opcode, req_key);
            if (req_opcode != OP_INSERT) presence_q.push_back(want);
         end
         if (rsp_valid) begin
            if (presence_q.size() == 0) begin
               $display("%0t: unexpected result beat, maybe_present %0b",
                        $time, rsp_maybe_present);
               fail_count++;
            end else begin
               want = presence_q.pop_front();
               if (rsp_maybe_present !== want) begin
                  $display("%0t: maybe_present expected %0b actual %0b",
                           $time, want, rsp_maybe_present);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the bloom filter core
// ---------------------------------------------------------------------------
// Directed keys at the extremes, then random inserts and finds over several
// filter sizes and probe counts, with random gaps; a checker beside the core
// predicts every find result.
`timescale 1ns / 1ps
module testbench;
   import bfm64_pkg::*;

   localparam logic OP_FIND = 1'b1;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_opcode;
   logic signed [63:0] req_key;
   logic              rsp_valid;
   logic              rsp_maybe_present;
   logic              csr_we;
   logic [0:0]        csr_index;
   logic [CFG_W-1:0]  csr_wdata;
   int                fail_count;
   int                pending;

   logic [63:0] inserted_keys [$];
   int          no_idle_left;

   bloom_filter_murmur64_int_keys_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_maybe_present(rsp_maybe_present),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bloom_filter_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_maybe_present(rsp_maybe_present),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop, well past the slowest legal run incl. the clearing pass
   initial begin
      #40_000_000;
      $display("bloom_filter_murmur64_int_keys_core test failed");
      $finish;
   end

   // one beat: hold start until a cycle with busy low, sampled mid-cycle
   task automatic send_key(input logic op, input logic [63:0] k);
      logic free;
      begin
         start <= 1'b1;
         req_opcode <= op;
         req_key <= k;
         do begin
            @(negedge clock);
            free = !busy;
            @(posedge clock);
         end while (!free);
         if (op == OP_INSERT) inserted_keys.push_back(k);
         // random gap after the beat, except in the no-idle stretch
         if (no_idle_left > 0) begin
            no_idle_left--;
         end else if ($urandom_range(99) < 26) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   endtask

   // wait for all finds answered and the core idle, then wait on with start low
   task automatic drain;
      begin
         start <= 1'b0;
         @(posedge clock);
         while (pending != 0 || busy) @(posedge clock);
         repeat (700) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] v);
      begin
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= v;
         @(posedge clock);
         csr_we <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [63:0] pick_key;
      begin
         // inserted keys in under half the picks so finds hit, else a signed extreme or a fresh key
         if (inserted_keys.size() != 0 && $urandom_range(99) < 45)
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         if ($urandom_range(99) < 5)
            return $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
         return {$urandom, $urandom};
      end
   endfunction

   task automatic random_phase(input int n);
      begin
         for (int i = 0; i < n; i++)
            send_key($urandom_range(1) ? OP_FIND : OP_INSERT, pick_key());
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_INSERT;
      req_key = '0;
      csr_we = 1'b0;
      csr_index = REG_BIT_COUNT;
      csr_wdata = '0;
      no_idle_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed keys under the reset settings: extremes, hits and misses
      send_key(OP_FIND, 64'd0);
      send_key(OP_INSERT, 64'd0);
      send_key(OP_FIND, 64'd0);
      send_key(OP_INSERT, 64'h7fff_ffff_ffff_ffff);
      send_key(OP_INSERT, 64'h8000_0000_0000_0000);
      send_key(OP_INSERT, 64'hffff_ffff_ffff_ffff);
      send_key(OP_FIND, 64'h7fff_ffff_ffff_ffff);
      send_key(OP_FIND, 64'h8000_0000_0000_0000);
      send_key(OP_FIND, 64'hffff_ffff_ffff_ffff);
      send_key(OP_FIND, 64'd1);
      send_key(OP_FIND, 64'h5555_5555_5555_5555);
      send_key(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa);
      send_key(OP_FIND, 64'haaaa_aaaa_aaaa_aaaa);
      // sender holds off until every find is answered
      drain();

      // long stretch with no idling
      no_idle_left = 120;
      random_phase(150);
      drain();

      // smallest filter, probe count zero clamps to one
      write_reg(REG_BIT_COUNT, 17'd0);
      write_reg(REG_HASH_COUNT, 17'd0);
      random_phase(130);
      drain();

      // size not a multiple of eight, probe count above the maximum
      write_reg(REG_BIT_COUNT, 17'd100);
      write_reg(REG_HASH_COUNT, 17'd31);
      random_phase(130);
      drain();

      // all-ones size clamps to the maximum, upper register bits ignored
      write_reg(REG_BIT_COUNT, 17'h1ffff);
      write_reg(REG_HASH_COUNT, 17'h1ffe0 | 17'd16);
      random_phase(130);
      drain();

      // size just below the maximum rounds up, single probe
      write_reg(REG_BIT_COUNT, 17'd65535);
      write_reg(REG_HASH_COUNT, 17'd1);
      random_phase(130);
      drain();

      // mid size and the exact lower bound
      write_reg(REG_BIT_COUNT, 17'd1000);
      write_reg(REG_HASH_COUNT, 17'd3);
      random_phase(100);
      drain();
      write_reg(REG_BIT_COUNT, 17'd64);
      write_reg(REG_HASH_COUNT, 17'd16);
      random_phase(100);
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("bloom_filter_murmur64_int_keys_core test passed");
      end else begin
         if (pending != 0) $display("%0t: %0d results never came", $time, pending);
         $display("bloom_filter_murmur64_int_keys_core test failed");
      end
      $finish;
   end
endmodule
